### hw/rtl/scrmr_pkg.sv
package scrmr_pkg;

  // Eight rectangle edges, the two segment ends and up to two points per edge.
  localparam int NUM_EDGES = 8;
  localparam int NUM_PTS   = 18;
  localparam int NUM_PAIRS = NUM_PTS - 1;
  localparam int MAX_OUT   = 9;
  localparam int RANK_W    = 5;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_LOW_X  = 4'd0,
    CFG_P_LOW_Y  = 4'd1,
    CFG_P_HIGH_X = 4'd2,
    CFG_P_HIGH_Y = 4'd3,
    CFG_Q_LOW_X  = 4'd4,
    CFG_Q_LOW_Y  = 4'd5,
    CFG_Q_HIGH_X = 4'd6,
    CFG_Q_HIGH_Y = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic hit;
    logic coll;
  } edge_flags_t;

  typedef struct packed {
    logic                 valid;
    logic [NUM_PAIRS-1:0] keep;
  } piece_ctl_t;

endpackage

### hw/rtl/segment_clip_rect_minus_rect_core.sv
// The first result word of a segment passes the input register, the edge units with their
// dividers, the sort, the piece stage, the emit queue and the output register, in that order.
// Throughput: one segment per cycle while each yields one word; a segment with n words holds
// the result port until its last word (n up to 9), and busy rises while the emitter is behind.
// Reset (rst, synchronous, active high) clears all pipeline valid bits and zeros the
// rectangle registers. The receiver cannot stall: every word is shown for exactly one cycle.
module segment_clip_rect_minus_rect_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scrmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  output logic                                strobe,
  output logic signed [COORD_BITS-1:0]        piece_ax,
  output logic signed [COORD_BITS-1:0]        piece_ay,
  output logic signed [COORD_BITS-1:0]        piece_bx,
  output logic signed [COORD_BITS-1:0]        piece_by,
  output logic                                has_piece,
  output logic                                last_piece
);
  import scrmr_pkg::*;

  localparam int W        = COORD_BITS;
  // Must track the divider depth inside the edge unit.
  localparam int QB       = W + 2 + (W % 2);
  localparam int EDGE_LAT = QB / 2 + 4;

  // Rectangle registers. Writes land any time; the host must only write when idle, which the block does not enforce.
  logic signed [W-1:0] p_low_x, p_low_y, p_high_x, p_high_y;
  logic signed [W-1:0] q_low_x, q_low_y, q_high_x, q_high_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_low_x  <= '0;
      p_low_y  <= '0;
      p_high_x <= '0;
      p_high_y <= '0;
      q_low_x  <= '0;
      q_low_y  <= '0;
      q_high_x <= '0;
      q_high_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_P_LOW_X:  p_low_x  <= cfg_data;
        CFG_P_LOW_Y:  p_low_y  <= cfg_data;
        CFG_P_HIGH_X: p_high_x <= cfg_data;
        CFG_P_HIGH_Y: p_high_y <= cfg_data;
        CFG_Q_LOW_X:  q_low_x  <= cfg_data;
        CFG_Q_LOW_Y:  q_low_y  <= cfg_data;
        CFG_Q_HIGH_X: q_high_x <= cfg_data;
        CFG_Q_HIGH_Y: q_high_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each rectangle walks its corners as left, top, right, bottom edges.
  // fix_y marks edges whose fixed coordinate is y.
  logic signed [W-1:0] e_ux [NUM_EDGES], e_uy [NUM_EDGES];
  logic signed [W-1:0] e_vx [NUM_EDGES], e_vy [NUM_EDGES];
  logic                e_fy [NUM_EDGES];
  logic signed [W-1:0] rlx, rly, rhx, rhy;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      rlx = (r == 0) ? p_low_x  : q_low_x;
      rly = (r == 0) ? p_low_y  : q_low_y;
      rhx = (r == 0) ? p_high_x : q_high_x;
      rhy = (r == 0) ? p_high_y : q_high_y;
      e_ux[4*r]   = rlx; e_uy[4*r]   = rly; e_vx[4*r]   = rlx; e_vy[4*r]   = rhy;
      e_ux[4*r+1] = rlx; e_uy[4*r+1] = rhy; e_vx[4*r+1] = rhx; e_vy[4*r+1] = rhy;
      e_ux[4*r+2] = rhx; e_uy[4*r+2] = rhy; e_vx[4*r+2] = rhx; e_vy[4*r+2] = rly;
      e_ux[4*r+3] = rhx; e_uy[4*r+3] = rly; e_vx[4*r+3] = rlx; e_vy[4*r+3] = rly;
      e_fy[4*r]   = 1'b0;
      e_fy[4*r+1] = 1'b1;
      e_fy[4*r+2] = 1'b0;
      e_fy[4*r+3] = 1'b1;
    end
  end

  // The whole pipeline advances together; it only holds when a finished
  // segment is waiting and the emitter is still sending the previous one.
  logic       adv, take;
  piece_ctl_t pctl;

  assign adv  = !(pctl.valid && !take);
  assign busy = !adv;

  logic                v0;
  logic signed [W-1:0] s0 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0[0] <= start_x;
      s0[1] <= start_y;
      s0[2] <= end_x;
      s0[3] <= end_y;
    end
  end

  // The segment ends travel alongside the edge units so the gather sees them.
  logic                dl_v  [EDGE_LAT];
  logic signed [W-1:0] dl_st [EDGE_LAT][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < EDGE_LAT; k++) begin
        dl_v[k] <= 1'b0;
      end
    end else if (adv) begin
      dl_v[0] <= v0;
      for (int k = 1; k < EDGE_LAT; k++) begin
        dl_v[k] <= dl_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_st[0] <= s0;
      for (int k = 1; k < EDGE_LAT; k++) begin
        dl_st[k] <= dl_st[k-1];
      end
    end
  end

  logic signed [W-1:0] ec_x [NUM_EDGES], ec_y [NUM_EDGES];
  edge_flags_t         ef   [NUM_EDGES];

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
    scrmr_edge #(
      .COORD_BITS(COORD_BITS)
    ) u_edge (
      .clk   (clk),
      .en    (adv),
      .sx    (s0[0]),
      .sy    (s0[1]),
      .tx    (s0[2]),
      .ty    (s0[3]),
      .ux    (e_ux[g]),
      .uy    (e_uy[g]),
      .vx    (e_vx[g]),
      .vy    (e_vy[g]),
      .fix_y (e_fy[g]),
      .cx    (ec_x[g]),
      .cy    (ec_y[g]),
      .flags (ef[g])
    );
  end

  // Gather: two slots per edge. A crossing fills the first slot; an edge lying
  // on the segment's line fills both with its endpoints.
  logic signed [W-1:0] g_x [NUM_PTS], g_y [NUM_PTS];
  logic [NUM_PTS-1:0]  g_pv;

  always_comb begin
    g_x[0]  = dl_st[EDGE_LAT-1][0];
    g_y[0]  = dl_st[EDGE_LAT-1][1];
    g_x[1]  = dl_st[EDGE_LAT-1][2];
    g_y[1]  = dl_st[EDGE_LAT-1][3];
    g_pv[0] = 1'b1;
    g_pv[1] = 1'b1;
    for (int i = 0; i < NUM_EDGES; i++) begin
      g_x[2+2*i]  = ef[i].hit ? ec_x[i] : e_ux[i];
      g_y[2+2*i]  = ef[i].hit ? ec_y[i] : e_uy[i];
      g_pv[2+2*i] = ef[i].hit || ef[i].coll;
      g_x[3+2*i]  = e_vx[i];
      g_y[3+2*i]  = e_vy[i];
      g_pv[3+2*i] = ef[i].coll;
    end
  end

  logic                srt_v;
  logic signed [W-1:0] srt_x [NUM_PTS], srt_y [NUM_PTS];
  logic [NUM_PTS-1:0]  srt_pv;
  logic signed [W-1:0] srt_st [4];

  scrmr_sort #(
    .COORD_BITS(COORD_BITS)
  ) u_sort (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dl_v[EDGE_LAT-1]),
    .in_x      (g_x),
    .in_y      (g_y),
    .in_pv     (g_pv),
    .in_st     (dl_st[EDGE_LAT-1]),
    .out_valid (srt_v),
    .out_x     (srt_x),
    .out_y     (srt_y),
    .out_pv    (srt_pv),
    .out_st    (srt_st)
  );

  logic signed [W-1:0] pc_x [NUM_PTS], pc_y [NUM_PTS];

  scrmr_piece #(
    .COORD_BITS(COORD_BITS)
  ) u_piece (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (srt_v),
    .in_x     (srt_x),
    .in_y     (srt_y),
    .in_pv    (srt_pv),
    .in_st    (srt_st),
    .p_low_x  (p_low_x),
    .p_low_y  (p_low_y),
    .p_high_x (p_high_x),
    .p_high_y (p_high_y),
    .q_low_x  (q_low_x),
    .q_low_y  (q_low_y),
    .q_high_x (q_high_x),
    .q_high_y (q_high_y),
    .ctl      (pctl),
    .out_x    (pc_x),
    .out_y    (pc_y)
  );

  scrmr_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (pctl),
    .in_x       (pc_x),
    .in_y       (pc_y),
    .take       (take),
    .strobe     (strobe),
    .piece_ax   (piece_ax),
    .piece_ay   (piece_ay),
    .piece_bx   (piece_bx),
    .piece_by   (piece_by),
    .has_piece  (has_piece),
    .last_piece (last_piece)
  );

endmodule

### hw/rtl/scrmr_edge.sv
module scrmr_edge #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] tx,
  input  logic signed [COORD_BITS-1:0] ty,
  input  logic signed [COORD_BITS-1:0] ux,
  input  logic signed [COORD_BITS-1:0] uy,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic                         fix_y,
  output logic signed [COORD_BITS-1:0] cx,
  output logic signed [COORD_BITS-1:0] cy,
  output scrmr_pkg::edge_flags_t       flags
);
  import scrmr_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int D  = W + 1;
  localparam int PW = 2 * D;
  localparam int QB = W + 2 + (W % 2);
  localparam int NS = QB / 2;

  function automatic logic signed [D-1:0] ext(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  logic signed [W-1:0] s_f, t_f, s_g, t_g, u_f, u_g, v_g, lo_g, hi_g;

  always_comb begin
    s_f  = fix_y ? sy : sx;
    t_f  = fix_y ? ty : tx;
    s_g  = fix_y ? sx : sy;
    t_g  = fix_y ? tx : ty;
    u_f  = fix_y ? uy : ux;
    u_g  = fix_y ? ux : uy;
    v_g  = fix_y ? vx : vy;
    lo_g = (u_g < v_g) ? u_g : v_g;
    hi_g = (u_g < v_g) ? v_g : u_g;
  end

  // Differences against the segment start.
  logic signed [D-1:0] a_df, a_dg, a_kf, a_dlo, a_dhi, a_dx, a_dy, a_ex, a_ey;
  logic                a_denz;
  logic signed [W-1:0] a_sg, a_uf;

  always_ff @(posedge clk) begin
    if (en) begin
      a_df   <= ext(t_f) - ext(s_f);
      a_dg   <= ext(t_g) - ext(s_g);
      a_kf   <= ext(u_f) - ext(s_f);
      a_dlo  <= ext(lo_g) - ext(s_g);
      a_dhi  <= ext(hi_g) - ext(s_g);
      a_dx   <= ext(tx) - ext(sx);
      a_dy   <= ext(ty) - ext(sy);
      a_ex   <= ext(ux) - ext(sx);
      a_ey   <= ext(uy) - ext(sy);
      a_denz <= (u_g != v_g);
      a_sg   <= s_g;
      a_uf   <= u_f;
    end
  end

  // Exact products for the range test and the on-line test.
  logic signed [PW-1:0] b_p0, b_p1, b_p2, b_c1, b_c2;
  logic signed [D-1:0]  b_df;
  logic                 b_denz;
  logic signed [W-1:0]  b_sg, b_uf;

  always_ff @(posedge clk) begin
    if (en) begin
      b_p0   <= a_dg * a_kf;
      b_p1   <= a_dlo * a_df;
      b_p2   <= a_dhi * a_df;
      b_c1   <= a_dx * a_ey;
      b_c2   <= a_dy * a_ex;
      b_df   <= a_df;
      b_denz <= a_denz;
      b_sg   <= a_sg;
      b_uf   <= a_uf;
    end
  end

  logic          cross_ok, in_rng;
  logic [PW-1:0] mag_n;
  logic [D-1:0]  mag_d;

  always_comb begin
    cross_ok = (b_df != '0) && b_denz;
    if (!b_df[D-1]) begin
      in_rng = (b_p0 >= b_p1) && (b_p0 <= b_p2);
    end else begin
      in_rng = (b_p0 <= b_p1) && (b_p0 >= b_p2);
    end
    mag_n = b_p0[PW-1] ? PW'(-b_p0) : PW'(b_p0);
    mag_d = b_df[D-1] ? D'(-b_df) : D'(b_df);
  end

  // Restoring divider, two quotient bits per stage. The offset lies on the
  // edge, so the quotient always fits in QB bits when the point is used.
  logic [D-1:0]        dv_r   [NS+1];
  logic [QB-1:0]       dv_n   [NS+1];
  logic [QB-1:0]       dv_q   [NS+1];
  logic [D-1:0]        dv_d   [NS+1];
  logic                dv_neg [NS+1];
  edge_flags_t         dv_f   [NS+1];
  logic signed [W-1:0] dv_sg  [NS+1];
  logic signed [W-1:0] dv_uf  [NS+1];

  logic [D-1:0]  nr [NS];
  logic [QB-1:0] nn [NS];
  logic [QB-1:0] nq [NS];

  always_comb begin
    for (int st = 0; st < NS; st++) begin : div_step
      logic [D:0]    dt;
      logic [D-1:0]  dr;
      logic [QB-1:0] dn;
      logic [QB-1:0] dq;
      dr = dv_r[st];
      dn = dv_n[st];
      dq = dv_q[st];
      for (int b = 0; b < 2; b++) begin
        dt = {dr, dn[QB-1]};
        if (dt >= {1'b0, dv_d[st]}) begin
          dt = dt - {1'b0, dv_d[st]};
          dq = {dq[QB-2:0], 1'b1};
        end else begin
          dq = {dq[QB-2:0], 1'b0};
        end
        dr = dt[D-1:0];
        dn = {dn[QB-2:0], 1'b0};
      end
      nr[st] = dr;
      nn[st] = dn;
      nq[st] = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= D'(mag_n[PW-1:QB]);
      dv_n[0]   <= mag_n[QB-1:0];
      dv_q[0]   <= '0;
      dv_d[0]   <= mag_d;
      dv_neg[0] <= b_p0[PW-1] ^ b_df[D-1];
      dv_f[0]   <= '{hit: cross_ok && in_rng, coll: !cross_ok && (b_c1 == b_c2)};
      dv_sg[0]  <= b_sg;
      dv_uf[0]  <= b_uf;
      for (int st = 1; st <= NS; st++) begin
        dv_r[st]   <= nr[st-1];
        dv_n[st]   <= nn[st-1];
        dv_q[st]   <= nq[st-1];
        dv_d[st]   <= dv_d[st-1];
        dv_neg[st] <= dv_neg[st-1];
        dv_f[st]   <= dv_f[st-1];
        dv_sg[st]  <= dv_sg[st-1];
        dv_uf[st]  <= dv_uf[st-1];
      end
    end
  end

  // Round to nearest with ties away from zero, then apply the sign.
  logic                 rnd_up;
  logic [QB:0]          q_rnd;
  logic signed [QB+1:0] off, g_sum;
  logic signed [W-1:0]  cg_r, cf_r;

  always_comb begin
    rnd_up = ({dv_r[NS], 1'b0} >= {1'b0, dv_d[NS]});
    q_rnd  = {1'b0, dv_q[NS]} + (QB+1)'(rnd_up);
    off    = dv_neg[NS] ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
    g_sum  = {{(QB+2-W){dv_sg[NS][W-1]}}, dv_sg[NS]} + off;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cg_r  <= g_sum[W-1:0];
      cf_r  <= dv_uf[NS];
      flags <= dv_f[NS];
    end
  end

  assign cx = fix_y ? cg_r : cf_r;
  assign cy = fix_y ? cf_r : cg_r;

endmodule

### hw/rtl/scrmr_sort.sv
module scrmr_sort #(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   in_x   [scrmr_pkg::NUM_PTS],
  input  logic signed [COORD_BITS-1:0]   in_y   [scrmr_pkg::NUM_PTS],
  input  logic [scrmr_pkg::NUM_PTS-1:0]  in_pv,
  input  logic signed [COORD_BITS-1:0]   in_st  [4],
  output logic                           out_valid,
  output logic signed [COORD_BITS-1:0]   out_x  [scrmr_pkg::NUM_PTS],
  output logic signed [COORD_BITS-1:0]   out_y  [scrmr_pkg::NUM_PTS],
  output logic [scrmr_pkg::NUM_PTS-1:0]  out_pv,
  output logic signed [COORD_BITS-1:0]   out_st [4]
);
  import scrmr_pkg::*;

  localparam int W = COORD_BITS;

  logic                v0, v1, v2;
  logic signed [W-1:0] x0 [NUM_PTS], y0 [NUM_PTS];
  logic signed [W-1:0] x1 [NUM_PTS], y1 [NUM_PTS];
  logic signed [W-1:0] x2 [NUM_PTS], y2 [NUM_PTS];
  logic [NUM_PTS-1:0]  pv0, pv1, pv2;
  logic signed [W-1:0] st0 [4], st1 [4], st2 [4];
  logic [NUM_PTS-1:0]  c_n [NUM_PTS];
  logic [NUM_PTS-1:0]  c1  [NUM_PTS];
  logic [RANK_W-1:0]   rank2 [NUM_PTS];
  logic signed [W-1:0] sx_n [NUM_PTS], sy_n [NUM_PTS];
  logic [NUM_PTS-1:0]  spv_n;

  // c_n[i][j] is set when point j sorts ahead of point i. Unused slots go last.
  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        if (i == j) begin
          c_n[i][j] = 1'b0;
        end else if (pv0[j] != pv0[i]) begin
          c_n[i][j] = pv0[j];
        end else if (!pv0[j]) begin
          c_n[i][j] = (j < i);
        end else begin
          c_n[i][j] = (x0[j] < x0[i]) ||
                      ((x0[j] == x0[i]) && ((y0[j] < y0[i]) ||
                                            ((y0[j] == y0[i]) && (j < i))));
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PTS; k++) begin
      sx_n[k]  = '0;
      sy_n[k]  = '0;
      spv_n[k] = 1'b0;
      for (int i = 0; i < NUM_PTS; i++) begin
        if (rank2[i] == RANK_W'(k)) begin
          sx_n[k]  = sx_n[k] | x2[i];
          sy_n[k]  = sy_n[k] | y2[i];
          spv_n[k] = spv_n[k] | pv2[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0     <= in_x;
      y0     <= in_y;
      pv0    <= in_pv;
      st0    <= in_st;
      x1     <= x0;
      y1     <= y0;
      pv1    <= pv0;
      st1    <= st0;
      c1     <= c_n;
      x2     <= x1;
      y2     <= y1;
      pv2    <= pv1;
      st2    <= st1;
      for (int i = 0; i < NUM_PTS; i++) begin
        rank2[i] <= RANK_W'($countones(c1[i]));
      end
      out_x  <= sx_n;
      out_y  <= sy_n;
      out_pv <= spv_n;
      out_st <= st2;
    end
  end

endmodule

### hw/rtl/scrmr_piece.sv
module scrmr_piece #(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   in_x  [scrmr_pkg::NUM_PTS],
  input  logic signed [COORD_BITS-1:0]   in_y  [scrmr_pkg::NUM_PTS],
  input  logic [scrmr_pkg::NUM_PTS-1:0]  in_pv,
  input  logic signed [COORD_BITS-1:0]   in_st [4],
  input  logic signed [COORD_BITS-1:0]   p_low_x,
  input  logic signed [COORD_BITS-1:0]   p_low_y,
  input  logic signed [COORD_BITS-1:0]   p_high_x,
  input  logic signed [COORD_BITS-1:0]   p_high_y,
  input  logic signed [COORD_BITS-1:0]   q_low_x,
  input  logic signed [COORD_BITS-1:0]   q_low_y,
  input  logic signed [COORD_BITS-1:0]   q_high_x,
  input  logic signed [COORD_BITS-1:0]   q_high_y,
  output scrmr_pkg::piece_ctl_t          ctl,
  output logic signed [COORD_BITS-1:0]   out_x [scrmr_pkg::NUM_PTS],
  output logic signed [COORD_BITS-1:0]   out_y [scrmr_pkg::NUM_PTS]
);
  import scrmr_pkg::*;

  localparam int W = COORD_BITS;
  localparam int D = W + 1;

  function automatic logic signed [D-1:0] ext(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic signed [D-1:0] dbl(input logic signed [W-1:0] v);
    return {v, 1'b0};
  endfunction

  function automatic logic [NUM_PTS-1:0] pfx_mask(input int k);
    logic [NUM_PTS-1:0] m;
    for (int j = 0; j < NUM_PTS; j++) begin
      m[j] = (j <= k);
    end
    return m;
  endfunction

  logic [NUM_PAIRS-1:0] okm_n, dif_n, okm1, dif1;
  logic [NUM_PTS-1:0]   tog_n, tog1, uniq;
  logic                 v1;
  logic signed [W-1:0]  x1 [NUM_PTS], y1 [NUM_PTS];
  logic signed [D-1:0]  mx, my;
  logic                 inp, inq;
  logic [NUM_PAIRS-1:0] keep_n;

  // Midpoint tests at doubled scale, and where distinct neighbors sit.
  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      mx = ext(in_x[k]) + ext(in_x[k+1]);
      my = ext(in_y[k]) + ext(in_y[k+1]);
      inp = (dbl(p_low_x) < mx) && (mx < dbl(p_high_x)) &&
            (dbl(p_low_y) < my) && (my < dbl(p_high_y));
      inq = (dbl(q_low_x) <= mx) && (mx <= dbl(q_high_x)) &&
            (dbl(q_low_y) <= my) && (my <= dbl(q_high_y));
      okm_n[k] = inp && !inq;
      dif_n[k] = in_pv[k+1] && ((in_x[k+1] != in_x[k]) || (in_y[k+1] != in_y[k]));
    end
    uniq[0] = in_pv[0];
    for (int k = 1; k < NUM_PTS; k++) begin
      uniq[k] = in_pv[k] && dif_n[k-1];
    end
    for (int k = 0; k < NUM_PTS; k++) begin
      tog_n[k] = uniq[k] &&
                 (((in_x[k] == in_st[0]) && (in_y[k] == in_st[1])) !=
                  ((in_x[k] == in_st[2]) && (in_y[k] == in_st[3])));
    end
  end

  // A piece lies within the segment while the running parity is set.
  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      keep_n[k] = dif1[k] && okm1[k] && (^(tog1 & pfx_mask(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      ctl.valid <= v1;
      ctl.keep  <= keep_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okm1     <= okm_n;
      dif1     <= dif_n;
      tog1     <= tog_n;
      x1       <= in_x;
      y1       <= in_y;
      out_x    <= x1;
      out_y    <= y1;
    end
  end

endmodule

### hw/rtl/scrmr_emit.sv
module scrmr_emit #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  scrmr_pkg::piece_ctl_t        in_ctl,
  input  logic signed [COORD_BITS-1:0] in_x [scrmr_pkg::NUM_PTS],
  input  logic signed [COORD_BITS-1:0] in_y [scrmr_pkg::NUM_PTS],
  output logic                         take,
  output logic                         strobe,
  output logic signed [COORD_BITS-1:0] piece_ax,
  output logic signed [COORD_BITS-1:0] piece_ay,
  output logic signed [COORD_BITS-1:0] piece_bx,
  output logic signed [COORD_BITS-1:0] piece_by,
  output logic                         has_piece,
  output logic                         last_piece
);
  import scrmr_pkg::*;

  localparam int W = COORD_BITS;

  logic                 cur_valid;
  logic [NUM_PAIRS-1:0] cur_mask, rest;
  logic [CNT_W-1:0]     cur_cnt;
  logic signed [W-1:0]  cur_x [NUM_PTS], cur_y [NUM_PTS];
  logic [RANK_W-1:0]    sel;
  logic                 fin;

  // Lowest remaining piece goes out first; the ninth word ends the segment.
  always_comb begin
    sel = '0;
    for (int k = NUM_PAIRS - 1; k >= 0; k--) begin
      if (cur_mask[k]) begin
        sel = RANK_W'(k);
      end
    end
    rest = cur_mask & ~(NUM_PAIRS'(1) << sel);
    fin  = cur_valid && ((rest == '0) || (cur_cnt == CNT_W'(MAX_OUT - 1)));
    take = !cur_valid || fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= cur_valid;
      if (take) begin
        cur_valid <= in_ctl.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_valid) begin
      cur_mask <= rest;
      cur_cnt  <= cur_cnt + CNT_W'(1);
    end
    if (take && in_ctl.valid) begin
      cur_mask <= in_ctl.keep;
      cur_cnt  <= '0;
      cur_x    <= in_x;
      cur_y    <= in_y;
    end
    has_piece  <= (cur_mask != '0);
    last_piece <= fin;
    piece_ax   <= (cur_mask != '0) ? cur_x[sel] : '0;
    piece_ay   <= (cur_mask != '0) ? cur_y[sel] : '0;
    piece_bx   <= (cur_mask != '0) ? cur_x[sel + RANK_W'(1)] : '0;
    piece_by   <= (cur_mask != '0) ? cur_y[sel + RANK_W'(1)] : '0;
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_piece |-> last_piece)
    else $error("empty result word not marked last");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_piece |=> strobe)
    else $error("gap inside one segment's result words");

  a_nonlast_has_piece: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_piece |-> has_piece)
    else $error("non-final result word without a piece");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur_cnt < CNT_W'(MAX_OUT))
    else $error("more than nine pieces sent for one segment");

endmodule

### test/scrmr_checker.sv
`timescale 1ns / 1ps

module scrmr_checker
  import scrmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               strobe,
  input  logic signed [31:0] piece_ax,
  input  logic signed [31:0] piece_ay,
  input  logic signed [31:0] piece_bx,
  input  logic signed [31:0] piece_by,
  input  logic               has_piece,
  input  logic               last_piece,
  output int                 fail_count,
  output int                 pending,
  output int                 pieces_seen
);

  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by;
    logic               has, last;
  } piece_t;

  piece_t expected_pieces[$];
  longint rect[8];

  function automatic int prod_sign(longint a, longint b, longint c, longint d);
    logic signed [127:0] wa, wb, wc, wd, x;
    wa = a; wb = b; wc = c; wd = d;
    x = wa * wb - wc * wd;
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  // Rounded quotient n1*n2/d, ties away from zero.
  function automatic longint round_quot(longint n1, longint n2, longint d);
    logic signed [127:0] wn1, wn2, wd, wn;
    logic [127:0] n, dm, q, r;
    int neg;
    wn1 = n1; wn2 = n2; wd = d;
    wn = wn1 * wn2;
    n = (wn < 0) ? -wn : wn;
    dm = (wd < 0) ? -wd : wd;
    q = n / dm;
    r = n % dm;
    if (2 * r >= dm) q = q + 1;
    q = q & ((128'd1 << 62) - 1);
    neg = ((n1 < 0) ^ (n2 < 0) ^ (d < 0)) && n1 != 0 && n2 != 0;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void predict_pieces(longint sx, longint sy, longint ex, longint ey);
    longint pc[18][2];
    longint eu[8][2], ev[8][2];
    longint xs[5], ys[5], s[2], t[2], dx, dy, df, dg, de, kf, lo, hi, mx, my, tmp0, tmp1;
    int eax[8];
    int n, cnt, ax, fr, sd, j;
    bit par, inp, inq, ls, lt;
    piece_t pc_out;
    s[0] = sx; s[1] = sy; t[0] = ex; t[1] = ey;
    dx = ex - sx; dy = ey - sy;
    for (int r = 0; r < 2; r++) begin
      xs = '{rect[4*r], rect[4*r], rect[4*r+2], rect[4*r+2], rect[4*r]};
      ys = '{rect[4*r+1], rect[4*r+3], rect[4*r+3], rect[4*r+1], rect[4*r+1]};
      for (int k = 0; k < 4; k++) begin
        eu[4*r+k][0] = xs[k];   eu[4*r+k][1] = ys[k];
        ev[4*r+k][0] = xs[k+1]; ev[4*r+k][1] = ys[k+1];
        eax[4*r+k] = k & 1;
      end
    end
    pc[0] = s; pc[1] = t; n = 2;
    for (int i = 0; i < 8; i++) begin
      ax = eax[i]; fr = 1 - ax;
      df = t[ax] - s[ax]; dg = t[fr] - s[fr];
      de = ev[i][fr] - eu[i][fr]; kf = eu[i][ax] - s[ax];
      if (df != 0 && de != 0) begin
        lo = (eu[i][fr] < ev[i][fr]) ? eu[i][fr] : ev[i][fr];
        hi = (eu[i][fr] < ev[i][fr]) ? ev[i][fr] : eu[i][fr];
        sd = (df > 0) ? 1 : -1;
        if (sd * prod_sign(dg, kf, lo - s[fr], df) >= 0 &&
            sd * prod_sign(dg, kf, hi - s[fr], df) <= 0 && n < 18) begin
          pc[n][ax] = eu[i][ax];
          pc[n][fr] = s[fr] + round_quot(dg, kf, df);
          n++;
        end
      end else if (prod_sign(dx, eu[i][1] - s[1], dy, eu[i][0] - s[0]) == 0) begin
        if (n + 2 <= 18) begin
          pc[n] = eu[i]; pc[n+1] = ev[i]; n += 2;
        end
      end
    end
    // Insertion sort by x, then y, then drop repeats.
    for (int i = 1; i < n; i++) begin
      tmp0 = pc[i][0]; tmp1 = pc[i][1]; j = i;
      while (j > 0 && (tmp0 < pc[j-1][0] || (tmp0 == pc[j-1][0] && tmp1 < pc[j-1][1]))) begin
        pc[j] = pc[j-1]; j--;
      end
      pc[j][0] = tmp0; pc[j][1] = tmp1;
    end
    j = 1;
    for (int i = 1; i < n; i++)
      if (pc[i][0] != pc[j-1][0] || pc[i][1] != pc[j-1][1]) begin
        pc[j] = pc[i]; j++;
      end
    n = j;
    cnt = 0; par = 0;
    for (int i = 1; i < n && cnt < MAX_OUT; i++) begin
      ls = (pc[i-1][0] == s[0] && pc[i-1][1] == s[1]);
      lt = (pc[i-1][0] == t[0] && pc[i-1][1] == t[1]);
      par ^= (ls != lt);
      if (par) begin
        mx = pc[i-1][0] + pc[i][0];
        my = pc[i-1][1] + pc[i][1];
        inp = 2*rect[0] < mx && mx < 2*rect[2] && 2*rect[1] < my && my < 2*rect[3];
        inq = 2*rect[4] <= mx && mx <= 2*rect[6] && 2*rect[5] <= my && my <= 2*rect[7];
        if (inp && !inq) begin
          pc_out.ax = pc[i-1][0][31:0]; pc_out.ay = pc[i-1][1][31:0];
          pc_out.bx = pc[i][0][31:0];   pc_out.by = pc[i][1][31:0];
          pc_out.has = 1'b1; pc_out.last = 1'b0;
          expected_pieces.insert(expected_pieces.size(), pc_out);
          cnt++;
        end
      end
    end
    if (cnt == 0) begin
      pc_out = '0;
      pc_out.last = 1'b1;
      expected_pieces.insert(expected_pieces.size(), pc_out);
    end else begin
      expected_pieces[$].last = 1'b1;
    end
  endfunction

  assign pending = expected_pieces.size();

  always @(posedge clk) begin
    piece_t want, got;
    if (rst) begin
      for (int i = 0; i < 8; i++) rect[i] = 0;
      fail_count <= 0;
      pieces_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_P_LOW_X:  rect[0] = longint'($signed(cfg_data));
          CFG_P_LOW_Y:  rect[1] = longint'($signed(cfg_data));
          CFG_P_HIGH_X: rect[2] = longint'($signed(cfg_data));
          CFG_P_HIGH_Y: rect[3] = longint'($signed(cfg_data));
          CFG_Q_LOW_X:  rect[4] = longint'($signed(cfg_data));
          CFG_Q_LOW_Y:  rect[5] = longint'($signed(cfg_data));
          CFG_Q_HIGH_X: rect[6] = longint'($signed(cfg_data));
          CFG_Q_HIGH_Y: rect[7] = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (strobe) begin
        got = '{piece_ax, piece_ay, piece_bx, piece_by, has_piece, last_piece};
        pieces_seen <= pieces_seen + 1;
        if (expected_pieces.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pieces.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %h %b %b, got %h %h %h %h %b %b",
                       want.ax, want.ay, want.bx, want.by, want.has, want.last,
                       got.ax, got.ay, got.bx, got.by, got.has, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        predict_pieces(longint'(start_x), longint'(start_y), longint'(end_x), longint'(end_y));
    end
  end

endmodule

### test/tb_segment_clip_rect_minus_rect_core.sv
`timescale 1ns / 1ps

module tb_segment_clip_rect_minus_rect_core;
  import scrmr_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic strobe;
  logic signed [31:0] piece_ax, piece_ay, piece_bx, piece_by;
  logic has_piece, last_piece;
  int fail_count, pending, pieces_seen;
  int cycles = 0;
  int segs_sent = 0;
  // The testbench's own copy of the rectangles, used to aim random points.
  int rect_copy[8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_clip_rect_minus_rect_core dut (.*);

  scrmr_checker checker_i (.*);

  // A hard ceiling on run length, covering drains and every worst case gap.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Writes one rectangle register and waits for the channel to take the word.
  task automatic write_reg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    rect_copy[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Lets every expected word arrive, then covers the pipeline latency, since a
  // segment may still be in flight behind the last word that was predicted.
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // Start is dropped first so that nothing new enters while the pipeline
  // empties and the registers change.
  task automatic load_rects(int plx, int ply, int phx, int phy,
                            int qlx, int qly, int qhx, int qhy);
    @(negedge clk);
    start = 1'b0;
    drain();
    write_reg(CFG_P_LOW_X, plx);  write_reg(CFG_P_LOW_Y, ply);
    write_reg(CFG_P_HIGH_X, phx); write_reg(CFG_P_HIGH_Y, phy);
    write_reg(CFG_Q_LOW_X, qlx);  write_reg(CFG_Q_LOW_Y, qly);
    write_reg(CFG_Q_HIGH_X, qhx); write_reg(CFG_Q_HIGH_Y, qhy);
  endtask

  // Presents one segment after a random gap. With no gap, start stays high and
  // only the fields change, so back to back words go in on consecutive edges while busy is low.
  task automatic send_seg(int sx, int sy, int ex, int ey);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    start_x = sx; start_y = sy; end_x = ex; end_y = ey;
    do @(posedge clk); while (busy);
    segs_sent++;
  endtask

  // Random coordinate: mostly within eight units of the origin, often at or just off one of
  // the rectangles' corner values, sometimes anywhere in the full 32-bit range.
  function automatic int rand_coord(bit is_y);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
    if (pick < 8) return rect_copy[2 * $urandom_range(0, 3) + is_y] +
                         ($urandom_range(0, 2) - 1) * ($urandom_range(0, 1) ? 1 : ONE);
    return $urandom;
  endfunction

  task automatic random_segs(int count);
    int ax, ay, bx, by;
    repeat (count) begin
      ax = rand_coord(0); ay = rand_coord(1);
      bx = rand_coord(0); by = rand_coord(1);
      case ($urandom_range(0, 5))
        0: by = ay;                         // horizontal
        1: bx = ax;                         // vertical
        2: begin bx = ax; by = ay; end      // zero length
        default: ;
      endcase
      send_seg(ax, ay, bx, by);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) rect_copy[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at their reset values: P is empty, so every segment is empty.
    send_seg(-ONE, -ONE, ONE, ONE);
    send_seg(0, 0, 0, 0);

    // A common layout: Q sits inside P.
    load_rects(-4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, -ONE, -ONE, ONE, ONE);
    send_seg(-6 * ONE, 0, 6 * ONE, 0);                 // crosses both rectangles
    send_seg(6 * ONE, 0, -6 * ONE, 0);                 // same, reversed
    send_seg(0, -6 * ONE, 0, 6 * ONE);                 // vertical
    send_seg(-6 * ONE, -6 * ONE, 6 * ONE, 6 * ONE);    // diagonal through corners
    send_seg(-6 * ONE, 4 * ONE, 6 * ONE, 4 * ONE);     // collinear with P's top edge
    send_seg(-3 * ONE, ONE, 3 * ONE, ONE);             // collinear with Q's top edge
    send_seg(2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE);      // zero length, inside
    send_seg(4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE);      // zero length on a corner
    send_seg(-3 * ONE, -3 * ONE, 3 * ONE, 2 * ONE + 7);// rounded crossings
    send_seg(5 * ONE, 5 * ONE, 7 * ONE, 9 * ONE);      // entirely outside
    send_seg(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_seg(-2 * ONE, -3 * ONE, 3 * ONE, 2 * ONE);
    random_segs(50);

    // Extremes: P spans the whole range, Q is a single point.
    load_rects(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               0, 0, 0, 0);
    send_seg(-ONE, 0, ONE, 0);
    send_seg(32'sh80000000, 0, 32'sh7fffffff, 1);
    send_seg(32'sh80000001, 32'sh80000001, 32'sh7ffffffe, 32'sh7ffffffe);
    random_segs(35);

    // P given with its corners swapped contains nothing.
    load_rects(3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, -ONE, -ONE, ONE, ONE);
    send_seg(-5 * ONE, 0, 5 * ONE, 0);
    random_segs(15);

    // Q overlaps P's bottom edge, and its edges cut P into several runs.
    load_rects(-5 * ONE, -2 * ONE, 6 * ONE, 3 * ONE, 2 * ONE + 3, -4 * ONE,
               4 * ONE - 5, ONE / 2);
    send_seg(-7 * ONE, -3 * ONE, 7 * ONE, 2 * ONE);
    random_segs(70);

    @(negedge clk);
    start = 1'b0;
    drain();
    $display("Ran %0d segments over five rectangle setups; %0d result words were checked.",
             segs_sent, pieces_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
